### hw/rtl/cfm_pkg.sv
// Shared types and constants of the cassette FSK modem.
package cfm_pkg;

	// Transfer payload of one tick on the input channel
	typedef struct packed {
		logic tape_level;
		logic uart_tx_bit;
	} tick_t;

	// Transfer payload of one result on the output channel
	typedef struct packed {
		logic rx_bit_valid;
		logic rx_bit;
		logic drive_valid;
		logic drive_level;
		logic deck;
	} result_t;

	// Configuration register contents
	typedef struct packed {
		logic rs232_selected;
		logic fast_baud;
		logic deck_select;
	} cfg_t;

	// Register word index (byte address / 4)
	typedef enum logic [1:0] {
		REG_RS232_SELECTED = 2'd0,
		REG_FAST_BAUD      = 2'd1,
		REG_DECK_SELECT    = 2'd2
	} reg_idx_t;

	localparam int unsigned ADDR_W        = 4;
	localparam int unsigned DATA_W        = 32;
	localparam int unsigned PHASE_W       = 5;
	localparam int unsigned SHORT_RUN_SLOW = 6;
	localparam int unsigned SHORT_RUN_FAST = 10;
	localparam int unsigned LONG_RUN       = 32;

endpackage

### hw/rtl/cassette_fsk_modem.sv
// Cassette FSK modem: tape tones to UART bits and UART bits to tape tones.
// Path: a tick passes through the input register, then the result register;
// the per-tick work is the state update in between.
// Throughput: one tick per cycle, held back only by a stalled result register.
// Reset clears the pipeline valids, the configuration and the modem state
// (decoded bit and drive level come up as 1).
module cassette_fsk_modem import cfm_pkg::*; #(
	parameter int unsigned RUN_COUNT_WIDTH = 6
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              tick_valid,
	output logic              tick_stall,
	input  tick_t             tick,
	output logic              result_valid,
	input  logic              result_stall,
	output result_t           result,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [ADDR_W-1:0] paddr,
	input  logic [DATA_W-1:0] pwdata,
	output logic [DATA_W-1:0] prdata,
	output logic              pready
);

	cfg_t    cfg;
	tick_t   tick_s1;
	logic    valid_s1;
	result_t res_s1;
	result_t result_q;
	logic    result_valid_q;
	logic    advance, fire;

	assign advance    = !result_valid_q || !result_stall;
	assign tick_stall = valid_s1 && !advance;
	assign fire       = valid_s1 && advance;

	cfm_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	cfm_core #(
		.RUN_COUNT_WIDTH (RUN_COUNT_WIDTH)
	) u_core (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg),
		.fire   (fire),
		.item   (tick_s1),
		.res    (res_s1)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!tick_stall) begin
			valid_s1 <= tick_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (tick_valid && !tick_stall) begin
			tick_s1 <= tick;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid_q <= 1'b0;
		end else if (advance) begin
			result_valid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			result_q <= res_s1;
		end
	end

	assign result_valid = result_valid_q;
	assign result       = result_q;

endmodule

### hw/rtl/cfm_regs.sv
// APB configuration registers of the cassette FSK modem.
module cfm_regs import cfm_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [ADDR_W-1:0] paddr,
	input  logic [DATA_W-1:0] pwdata,
	output logic [DATA_W-1:0] prdata,
	output logic              pready,
	output cfg_t              cfg
);

	cfg_t     cfg_q;
	reg_idx_t idx;
	logic     wr_en;
	logic     rd_bit;

	assign idx    = reg_idx_t'(paddr[ADDR_W-1:2]);
	assign wr_en  = psel && penable && pwrite;
	assign pready = 1'b1;
	assign cfg    = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '0;
		end else if (wr_en) begin
			case (idx)
				REG_RS232_SELECTED: cfg_q.rs232_selected <= pwdata[0];
				REG_FAST_BAUD:      cfg_q.fast_baud      <= pwdata[0];
				REG_DECK_SELECT:    cfg_q.deck_select    <= pwdata[0];
				default:            cfg_q                <= cfg_q;
			endcase
		end
	end

	always_comb begin
		case (idx)
			REG_RS232_SELECTED: rd_bit = cfg_q.rs232_selected;
			REG_FAST_BAUD:      rd_bit = cfg_q.fast_baud;
			REG_DECK_SELECT:    rd_bit = cfg_q.deck_select;
			default:            rd_bit = 1'b0;
		endcase
	end

	assign prdata = {{(DATA_W-1){1'b0}}, rd_bit};

endmodule

### hw/rtl/cfm_core.sv
// Modem state and the per-tick receive and send logic.
module cfm_core import cfm_pkg::*; #(
	parameter int unsigned RUN_COUNT_WIDTH = 6
) (
	input  logic    clk,
	input  logic    arst_n,
	input  cfg_t    cfg,
	input  logic    fire,
	input  tick_t   item,
	output result_t res
);

	localparam logic [RUN_COUNT_WIDTH-1:0] RUN_MAX = {RUN_COUNT_WIDTH{1'b1}};

	logic [RUN_COUNT_WIDTH-1:0] run_q, run_inc, run_d, short_lim;
	logic                       last_q, last_d;
	logic                       decoded_q, decoded_d;
	logic [PHASE_W-1:0]         phase_q, phase_inc, phase_d;
	logic                       send_q, send_d;
	logic                       level_q, level_d;
	logic                       changed, rx_hit, sample, toggle_slot, half, toggle;
	logic                       active;

	assign active = !cfg.rs232_selected;

	// receive: classify runs at a level change or SHORT_RUN_FAST (fast)
	always_comb begin
		run_inc   = (run_q < RUN_MAX) ? run_q + 1'b1 : run_q;
		short_lim = cfg.fast_baud ? RUN_COUNT_WIDTH'(SHORT_RUN_FAST)
		                          : RUN_COUNT_WIDTH'(SHORT_RUN_SLOW);
		changed   = item.tape_level != last_q;
		rx_hit    = changed || (cfg.fast_baud && run_inc == RUN_COUNT_WIDTH'(SHORT_RUN_FAST));
		decoded_d = decoded_q;
		if (rx_hit) begin
			decoded_d = (run_inc < short_lim) || (run_inc > RUN_COUNT_WIDTH'(LONG_RUN));
		end
		run_d  = changed ? '0 : run_inc;
		last_d = item.tape_level;
	end

	// send: latch the UART bit at a tone boundary, then toggle the drive
	always_comb begin
		phase_inc = phase_q + 1'b1;
		sample    = cfg.fast_baud ? (phase_inc[2:0] == 3'd0) : (phase_inc == '0);
		send_d    = send_q;
		phase_d   = phase_inc;
		if (sample && (item.uart_tx_bit != send_q)) begin
			send_d  = item.uart_tx_bit;
			phase_d = '0;
		end
		toggle_slot = cfg.fast_baud ? (phase_d[2:0] == 3'd0) : (phase_d[1:0] == 2'd0);
		half        = cfg.fast_baud ? phase_d[3] : phase_d[2];
		toggle      = toggle_slot && !(!send_d && half);
		level_d     = toggle ? !level_q : level_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q     <= '0;
			last_q    <= 1'b0;
			decoded_q <= 1'b1;
			phase_q   <= '0;
			send_q    <= 1'b0;
			level_q   <= 1'b1;
		end else if (fire && active) begin
			run_q     <= run_d;
			last_q    <= last_d;
			decoded_q <= decoded_d;
			phase_q   <= phase_d;
			send_q    <= send_d;
			level_q   <= level_d;
		end
	end

	always_comb begin
		res.rx_bit_valid = active && rx_hit;
		res.rx_bit       = active ? decoded_d : decoded_q;
		res.drive_valid  = active && toggle;
		res.drive_level  = active ? level_d : level_q;
		res.deck         = cfg.deck_select;
	end

endmodule

### hw/rtl/cfm_checker.sv
// Port-level checks of the cassette FSK modem, bound to the top level.
module cfm_checker import cfm_pkg::*; (
	input logic    clk,
	input logic    arst_n,
	input logic    tick_stall,
	input logic    result_valid,
	input logic    result_stall,
	input result_t result
);

	logic seen_q;
	logic last_rx_q;
	logic last_drive_q;
	logic out_xfer;

	assign out_xfer = result_valid && !result_stall;

	// remember the last delivered levels
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seen_q       <= 1'b0;
			last_rx_q    <= 1'b1;
			last_drive_q <= 1'b1;
		end else if (out_xfer) begin
			seen_q       <= 1'b1;
			last_rx_q    <= result.rx_bit;
			last_drive_q <= result.drive_level;
		end
	end

	a_result_hold: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result_stall |=> result_valid && $stable(result))
		else $error("result changed while stalled");

	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		tick_stall |-> result_valid && result_stall)
		else $error("input stalled while result side free");

	a_drive_steady: assert property (@(posedge clk) disable iff (!arst_n)
		out_xfer && seen_q && !result.drive_valid |-> result.drive_level == last_drive_q)
		else $error("drive level moved without a toggle");

	a_rx_steady: assert property (@(posedge clk) disable iff (!arst_n)
		out_xfer && seen_q && !result.rx_bit_valid |-> result.rx_bit == last_rx_q)
		else $error("decoded bit moved without a new bit");

endmodule

bind cassette_fsk_modem cfm_checker u_cfm_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.tick_stall   (tick_stall),
	.result_valid (result_valid),
	.result_stall (result_stall),
	.result       (result)
);

### tb/tb_modem_pkg.sv
// Scoreboard class for the cassette modem testbench: tick predictor and result checks.
`timescale 1ns / 1ps

package tb_modem_pkg;
	import cfm_pkg::*;

	localparam int unsigned RUN_W = 6;

	class fsk_tick_checker;
		// configuration copy
		logic rs232_on;
		logic fast_mode;
		logic deck_sel;

		// modem state copy
		logic [RUN_W-1:0]   run_len;
		logic               last_lvl;
		logic               dec_bit;
		logic [PHASE_W-1:0] phase;
		logic               snd_bit;
		logic               out_lvl;

		result_t want_results[$];

		int unsigned n_checked;
		int unsigned n_rx_bits;
		int unsigned n_toggles;
		int unsigned n_saturated;
		int unsigned n_ignored;
		int unsigned n_errors;

		function new();
			rs232_on    = 1'b0;
			fast_mode   = 1'b0;
			deck_sel    = 1'b0;
			run_len     = '0;
			last_lvl    = 1'b0;
			dec_bit     = 1'b1;
			phase       = '0;
			snd_bit     = 1'b0;
			out_lvl     = 1'b1;
			n_checked   = 0;
			n_rx_bits   = 0;
			n_toggles   = 0;
			n_saturated = 0;
			n_ignored   = 0;
			n_errors    = 0;
		endfunction

		function void write_reg(reg_idx_t idx, logic val);
			case (idx)
				REG_RS232_SELECTED: rs232_on  = val;
				REG_FAST_BAUD:      fast_mode = val;
				REG_DECK_SELECT:    deck_sel  = val;
				default: ;
			endcase
		endfunction

		function int unsigned pending();
			return want_results.size();
		endfunction

		// Advance the modem by one accepted tick and queue the result it produces.
		function void predict_tick(tick_t t);
			result_t            r;
			int unsigned        short_lim;
			logic [PHASE_W-1:0] sample_mask;
			logic [PHASE_W-1:0] toggle_mask;
			logic [PHASE_W-1:0] half_mask;
			logic               changed;
			r = '0;
			if (!rs232_on) begin
				short_lim   = fast_mode ? SHORT_RUN_FAST : SHORT_RUN_SLOW;
				sample_mask = fast_mode ? 5'h07 : 5'h1f;
				toggle_mask = fast_mode ? 5'h07 : 5'h03;
				half_mask   = fast_mode ? 5'h08 : 5'h04;

				if (run_len != {RUN_W{1'b1}})
					run_len = run_len + 1'b1;
				else
					n_saturated++;
				changed = (t.tape_level != last_lvl);
				if (changed || (fast_mode && run_len == SHORT_RUN_FAST)) begin
					dec_bit = (run_len < short_lim) || (run_len > LONG_RUN);
					r.rx_bit_valid = 1'b1;
					n_rx_bits++;
					if (changed) begin
						run_len  = '0;
						last_lvl = t.tape_level;
					end
				end

				phase = phase + 1'b1;
				// latch a new transmit bit only on a tone-period boundary
				if ((phase & sample_mask) == '0 && t.uart_tx_bit != snd_bit) begin
					snd_bit = t.uart_tx_bit;
					phase   = '0;
				end
				if ((phase & toggle_mask) == '0 &&
				    !(snd_bit == 1'b0 && (phase & half_mask) != '0)) begin
					out_lvl = ~out_lvl;
					r.drive_valid = 1'b1;
					n_toggles++;
				end
			end else begin
				n_ignored++;
			end
			r.rx_bit      = dec_bit;
			r.drive_level = out_lvl;
			r.deck        = deck_sel;
			want_results.push_back(r);
		endfunction

		function void cmp_field(string name, logic exp_v, logic got_v);
			if (got_v !== exp_v) begin
				$error("%s: expected %b, got %b", name, exp_v, got_v);
				n_errors++;
			end
		endfunction

		function void check_result(result_t got);
			result_t exp_r;
			if (want_results.size() == 0) begin
				$error("result transfer with nothing expected: %b", got);
				n_errors++;
				return;
			end
			exp_r = want_results.pop_front();
			n_checked++;
			cmp_field("rx_bit_valid", exp_r.rx_bit_valid, got.rx_bit_valid);
			cmp_field("rx_bit", exp_r.rx_bit, got.rx_bit);
			cmp_field("drive_valid", exp_r.drive_valid, got.drive_valid);
			cmp_field("drive_level", exp_r.drive_level, got.drive_level);
			cmp_field("deck", exp_r.deck, got.deck);
		endfunction
	endclass

endpackage

### tb/tb_top.sv
// Top-level testbench of the cassette FSK modem: stimulus, handshakes and run control.
`timescale 1ns / 1ps

module tb_top;
	import cfm_pkg::*;
	import tb_modem_pkg::*;

	localparam int unsigned ACTIVE_TICKS = 1850;
	localparam int unsigned LONG_HOLD    = 300;
	localparam int unsigned CYCLE_LIMIT  = 400000;

	logic              clk          = 1'b0;
	logic              arst_n       = 1'b0;
	logic              tick_valid   = 1'b0;
	logic              tick_stall;
	tick_t             tick         = '0;
	logic              result_valid;
	logic              result_stall = 1'b0;
	result_t           result;
	logic              psel         = 1'b0;
	logic              penable      = 1'b0;
	logic              pwrite       = 1'b0;
	logic [ADDR_W-1:0] paddr        = '0;
	logic [DATA_W-1:0] pwdata       = '0;
	logic [DATA_W-1:0] prdata;
	logic              pready;

	fsk_tick_checker chk = new();

	// tape and UART pattern generator state
	logic        gen_level   = 1'b0;
	int unsigned gen_lvl_left = 0;
	logic        gen_tx      = 1'b0;
	int unsigned gen_tx_left = 0;
	bit          gen_noisy   = 1'b0;

	bit          hold_req    = 1'b0;
	int unsigned n_holds     = 0;
	int unsigned n_active    = 0;
	int unsigned n_phases    = 0;

	cassette_fsk_modem #(.RUN_COUNT_WIDTH(RUN_W)) u_top (
		.clk          (clk),
		.arst_n       (arst_n),
		.tick_valid   (tick_valid),
		.tick_stall   (tick_stall),
		.tick         (tick),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.result       (result),
		.psel         (psel),
		.penable      (penable),
		.pwrite       (pwrite),
		.paddr        (paddr),
		.pwdata       (pwdata),
		.prdata       (prdata),
		.pready       (pready)
	);

	always #5 clk = ~clk;

	always @(posedge clk) begin
		if (arst_n) begin
			if (tick_valid && !tick_stall)
				chk.predict_tick(tick);
			if (result_valid && !result_stall)
				chk.check_result(result);
		end
	end

	// Run lengths around the decode thresholds, plus long idle runs that saturate.
	function automatic int unsigned pick_run_len();
		case ($urandom_range(0, 9))
			0, 1, 2: return $urandom_range(1, 5);
			3, 4:    return $urandom_range(6, 12);
			5:       return $urandom_range(8, 11);
			6:       return $urandom_range(13, 31);
			7:       return $urandom_range(31, 35);
			8:       return $urandom_range(36, 60);
			default: return $urandom_range(60, 90);
		endcase
	endfunction

	function automatic tick_t next_tape_tick();
		tick_t t;
		if (gen_noisy && $urandom_range(0, 19) == 0) begin
			t = tick_t'(2'($urandom_range(0, 3)));
			return t;
		end
		if (gen_lvl_left == 0) begin
			gen_level    = ~gen_level;
			gen_lvl_left = pick_run_len();
		end
		gen_lvl_left--;
		if (gen_tx_left == 0) begin
			gen_tx = ~gen_tx;
			case ($urandom_range(0, 2))
				0:       gen_tx_left = $urandom_range(1, 3);
				1:       gen_tx_left = $urandom_range(4, 40);
				default: gen_tx_left = $urandom_range(30, 120);
			endcase
		end
		gen_tx_left--;
		t.tape_level  = gen_level;
		t.uart_tx_bit = gen_tx;
		return t;
	endfunction

	task automatic send_tick(input tick_t t);
		tick_valid <= 1'b1;
		tick       <= t;
		@(posedge clk);
		while (tick_stall) @(posedge clk);
	endtask

	task automatic pause(input int unsigned n);
		tick_valid <= 1'b0;
		tick       <= tick_t'(2'($urandom_range(0, 3)));
		repeat (n) @(posedge clk);
	endtask

	// Drop valid and wait until every queued result has been checked.
	task automatic drain_results();
		tick_valid <= 1'b0;
		// let the monitor note the last accepted tick first
		@(posedge clk);
		while (chk.pending() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic apb_write(input reg_idx_t idx, input logic val);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= ADDR_W'({idx, 2'b00});
		pwdata  <= {31'($urandom()), val};
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready) @(posedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		chk.write_reg(idx, val);
	endtask

	task automatic set_config(input cfg_t c);
		apb_write(REG_RS232_SELECTED, c.rs232_selected);
		apb_write(REG_FAST_BAUD, c.fast_baud);
		apb_write(REG_DECK_SELECT, c.deck_select);
	endtask

	task automatic run_ticks(input int unsigned n, input bit no_gaps);
		int unsigned burst;
		burst = 0;
		for (int unsigned i = 0; i < n; i++) begin
			if (burst == 0) begin
				burst = $urandom_range(1, 40);
				if (!no_gaps && $urandom_range(0, 3) != 0)
					pause($urandom_range(1, 8));
			end
			send_tick(next_tape_tick());
			burst--;
		end
	endtask

	// Receiver: stall patterns of varying shape, with one long hold on request.
	initial begin : receiver
		int unsigned mode;
		int unsigned span;
		int unsigned per;
		wait (arst_n);
		@(posedge clk);
		forever begin
			if (hold_req) begin
				hold_req = 1'b0;
				result_stall <= 1'b1;
				repeat (LONG_HOLD) @(posedge clk);
				n_holds++;
			end
			mode = $urandom_range(0, 2);
			span = $urandom_range(16, 160);
			per  = $urandom_range(2, 7);
			for (int unsigned k = 0; k < span; k++) begin
				// start a requested hold right away
				if (hold_req)
					break;
				case (mode)
					0:       result_stall <= 1'b0;
					1:       result_stall <= ($urandom_range(0, 99) < 35);
					default: result_stall <= ((k % per) == 0);
				endcase
				@(posedge clk);
			end
		end
	end

	initial begin : watchdog
		int unsigned cyc;
		cyc = 0;
		while (cyc < CYCLE_LIMIT) begin
			@(posedge clk);
			cyc++;
		end
		$display("tb_top: FAIL");
		$finish;
	end

	initial begin : stimulus
		logic [15:0] slow_seq;
		cfg_t        cfg;
		int unsigned n;
		int unsigned p;
		bit          did_hold;
		bit          did_pause;
		slow_seq  = 16'b00_00_10_01_11_11_01_10;
		did_hold  = 1'b0;
		did_pause = 1'b0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: reset settings, then RS232 idle, then fast mode on the second deck
		for (int i = 7; i >= 0; i--)
			send_tick(tick_t'(slow_seq[2*i +: 2]));
		drain_results();
		apb_write(REG_RS232_SELECTED, 1'b1);
		send_tick(tick_t'(2'b11));
		send_tick(tick_t'(2'b00));
		send_tick(tick_t'(2'b10));
		drain_results();
		apb_write(REG_RS232_SELECTED, 1'b0);
		apb_write(REG_FAST_BAUD, 1'b1);
		apb_write(REG_DECK_SELECT, 1'b1);
		repeat (12) send_tick(tick_t'(2'b11));
		drain_results();

		// random phases: all eight settings first, then random ones
		p = 0;
		while (n_active < ACTIVE_TICKS) begin
			if (p < 8)
				cfg = cfg_t'(p[2:0]);
			else
				cfg = '{rs232_selected: ($urandom_range(0, 7) == 0),
				        fast_baud: 1'($urandom()), deck_select: 1'($urandom())};
			set_config(cfg);
			gen_noisy = ($urandom_range(0, 3) == 0);
			n_phases++;
			if (cfg.rs232_selected) begin
				run_ticks(30, 1'b0);
			end else begin
				n = $urandom_range(100, 200);
				n_active += n;
				if (!did_hold && p >= 2) begin
					// keep offering ticks while the receiver holds off
					did_hold = 1'b1;
					hold_req = 1'b1;
					run_ticks(n, 1'b1);
				end else if (!did_pause && did_hold) begin
					did_pause = 1'b1;
					run_ticks(n / 2, 1'b0);
					drain_results();
					run_ticks(n - n / 2, 1'b0);
				end else begin
					run_ticks(n, 1'b0);
				end
			end
			drain_results();
			p++;
		end
		repeat (10) @(posedge clk);

		$display("tb_top: %0d results checked, %0d setting phases, %0d ticks in RS232 idle",
		         chk.n_checked, n_phases, chk.n_ignored);
		$display("tb_top: %0d decoded bits, %0d toggles, %0d saturated ticks, %0d long holds",
		         chk.n_rx_bits, chk.n_toggles, chk.n_saturated, n_holds);
		if (chk.n_errors == 0 && chk.pending() == 0)
			$display("tb_top: PASS");
		else
			$display("tb_top: FAIL");
		$finish;
	end

endmodule
